// ===== rtl/ordered_list_store_top_macros.svh =====
// assertion macros used by the checker file of the ordered list store
`ifndef ORDERED_LIST_STORE_TOP_MACROS_SVH
`define ORDERED_LIST_STORE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define OLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ols_pkg.sv =====
// shared types, codes and defaults of the ordered list store
`default_nettype none

package ols_pkg;

    // default sizes
    localparam int CAPACITY_DEF  = 256;
    localparam int WORD_BITS_DEF = 32;

    // payload field widths
    localparam int ACT_W    = 2;
    localparam int POS_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 8;
    localparam int LEN_W    = 9;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

    // request transfer
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_req;

    // result transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FPOS_W-1:0]   found_position;
        logic [LEN_W-1:0]    length;
    } t_rsp;

    // finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_done;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_FD_RD,
        S_FD_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ols_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ols_ctrl.sv =====
// sequencer: checks a request, then walks the entry memory to shift or search
`default_nettype none

module ols_ctrl #(
    parameter int CAPACITY  = ols_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ols_pkg::WORD_BITS_DEF,
    localparam int CNT_W  = $clog2(CAPACITY + 1),
    localparam int ADDR_W = $clog2(CAPACITY)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire ols_pkg::t_req        i_in_data,
    output logic                      o_in_ready,
    input  wire logic                 i_slot_free,
    output ols_pkg::t_done            o_done,
    output logic                      o_we,
    output logic      [ADDR_W-1:0]    o_waddr,
    output logic      [WORD_BITS-1:0] o_wdata,
    output logic      [ADDR_W-1:0]    o_raddr,
    input  wire logic [WORD_BITS-1:0] i_rdata
);

    localparam int CMP_W = (CNT_W > ols_pkg::POS_W) ? CNT_W : ols_pkg::POS_W;

    ols_pkg::t_state                  r_state;
    ols_pkg::t_state                  n_state;
    logic [ols_pkg::ACT_W-1:0]        r_act;
    logic [ols_pkg::POS_W-1:0]        r_pos;
    logic [WORD_BITS-1:0]             r_word;
    logic [CNT_W-1:0]                 r_idx;
    logic [CNT_W-1:0]                 n_idx;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic [ols_pkg::STATUS_W-1:0]     r_status;
    logic [ols_pkg::STATUS_W-1:0]     n_status;
    logic [ols_pkg::FPOS_W-1:0]       r_where;
    logic [ols_pkg::FPOS_W-1:0]       n_where;

    logic             accept;
    logic             is_ins;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W:0]   pos_p1;
    logic [CNT_W-1:0] pos_n;
    logic [CNT_W-1:0] idx_dn;
    logic [CNT_W-1:0] idx_up;
    logic [CNT_W-1:0] idx_up2;
    logic             is_full;
    logic             is_empty;
    logic             ins_bad;
    logic             del_bad;
    logic             ins_shift;
    logic             del_shift;
    logic             sh_more;
    logic             hit;

    // request transfer only while no request is in work
    assign accept     = i_in_valid && (r_state == ols_pkg::S_IDLE);
    assign o_in_ready = (r_state == ols_pkg::S_IDLE);

    // position and index arithmetic
    assign is_ins    = (r_act == ols_pkg::ACT_INSERT);
    assign pos_c     = CMP_W'(r_pos);
    assign cnt_c     = CMP_W'(r_count);
    assign pos_p1    = (CMP_W + 1)'(pos_c) + (CMP_W + 1)'(1);
    assign pos_n     = CNT_W'(r_pos);
    assign idx_dn    = r_idx - CNT_W'(1);
    assign idx_up    = r_idx + CNT_W'(1);
    assign idx_up2   = r_idx + CNT_W'(2);

    // request checks
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign ins_bad   = (pos_c > cnt_c);
    assign del_bad   = (pos_c >= cnt_c);
    assign ins_shift = (cnt_c > pos_c);
    assign del_shift = (pos_p1 < (CMP_W + 1)'(cnt_c));

    // shift loop continues while entries remain to move
    assign sh_more = is_ins ? (CMP_W'(idx_dn) > pos_c) : (idx_up2 < r_count);
    assign hit     = (i_rdata == r_word);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ols_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ols_pkg::S_CHECK;
                end
            end
            ols_pkg::S_CHECK: begin
                case (r_act)
                    ols_pkg::ACT_INSERT: begin
                        if (is_full || ins_bad) begin
                            n_state = ols_pkg::S_DONE;
                        end else if (ins_shift) begin
                            n_state = ols_pkg::S_SH_RD;
                        end else begin
                            n_state = ols_pkg::S_PUT;
                        end
                    end
                    ols_pkg::ACT_DELETE: begin
                        if (is_empty || del_bad) begin
                            n_state = ols_pkg::S_DONE;
                        end else if (del_shift) begin
                            n_state = ols_pkg::S_SH_RD;
                        end else begin
                            n_state = ols_pkg::S_PUT;
                        end
                    end
                    ols_pkg::ACT_FIND: begin
                        if (is_empty) begin
                            n_state = ols_pkg::S_DONE;
                        end else begin
                            n_state = ols_pkg::S_FD_RD;
                        end
                    end
                    default: begin
                        n_state = ols_pkg::S_DONE;
                    end
                endcase
            end
            ols_pkg::S_SH_RD:  n_state = ols_pkg::S_SH_WR;
            ols_pkg::S_SH_WR: begin
                if (sh_more) begin
                    n_state = ols_pkg::S_SH_RD;
                end else begin
                    n_state = ols_pkg::S_PUT;
                end
            end
            ols_pkg::S_PUT:    n_state = ols_pkg::S_DONE;
            ols_pkg::S_FD_RD:  n_state = ols_pkg::S_FD_CMP;
            ols_pkg::S_FD_CMP: begin
                if (hit || !(idx_up < r_count)) begin
                    n_state = ols_pkg::S_DONE;
                end else begin
                    n_state = ols_pkg::S_FD_RD;
                end
            end
            ols_pkg::S_DONE: begin
                if (i_slot_free) begin
                    n_state = ols_pkg::S_IDLE;
                end
            end
            default: n_state = ols_pkg::S_IDLE;
        endcase
    end

    // datapath updates and memory accesses
    always_comb begin
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_where  = r_where;
        o_we     = 1'b0;
        o_waddr  = r_idx[ADDR_W-1:0];
        o_wdata  = i_rdata;
        o_raddr  = r_idx[ADDR_W-1:0];
        case (r_state)
            ols_pkg::S_CHECK: begin
                n_where  = '0;
                n_status = ols_pkg::STAT_OK;
                case (r_act)
                    ols_pkg::ACT_INSERT: begin
                        if (is_full) begin
                            n_status = ols_pkg::STAT_FULL;
                        end else if (ins_bad) begin
                            n_status = ols_pkg::STAT_BADPOS;
                        end
                        n_idx = r_count;
                    end
                    ols_pkg::ACT_DELETE: begin
                        if (is_empty) begin
                            n_status = ols_pkg::STAT_EMPTY;
                        end else if (del_bad) begin
                            n_status = ols_pkg::STAT_BADPOS;
                        end
                        n_idx = pos_n;
                    end
                    ols_pkg::ACT_FIND: begin
                        if (is_empty) begin
                            n_status = ols_pkg::STAT_NOTFOUND;
                        end
                        n_idx = '0;
                    end
                    default: begin
                        n_idx = r_idx;
                    end
                endcase
            end
            // fetch the neighbor that moves into the current slot
            ols_pkg::S_SH_RD: begin
                o_raddr = is_ins ? idx_dn[ADDR_W-1:0] : idx_up[ADDR_W-1:0];
            end
            // write it back one place over
            ols_pkg::S_SH_WR: begin
                o_we  = 1'b1;
                n_idx = is_ins ? idx_dn : idx_up;
            end
            // place the new word or drop the last slot
            ols_pkg::S_PUT: begin
                if (is_ins) begin
                    o_we    = 1'b1;
                    o_waddr = pos_n[ADDR_W-1:0];
                    o_wdata = r_word;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ols_pkg::S_FD_RD: begin
                o_raddr = r_idx[ADDR_W-1:0];
            end
            ols_pkg::S_FD_CMP: begin
                if (hit) begin
                    n_where = ols_pkg::FPOS_W'(r_idx);
                end else if (!(idx_up < r_count)) begin
                    n_status = ols_pkg::STAT_NOTFOUND;
                end else begin
                    n_idx = idx_up;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // finished result
    always_comb begin
        o_done.valid              = (r_state == ols_pkg::S_DONE);
        o_done.rsp.status         = r_status;
        o_done.rsp.found_position = r_where;
        o_done.rsp.length         = ols_pkg::LEN_W'(r_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ols_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_in_data.action;
            r_pos  <= i_in_data.position;
            r_word <= WORD_BITS'(i_in_data.value);
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_where  <= n_where;
    end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_store_top.sv =====
// ordered list store: entry memory, sequencer and output register
// one request at a time; insert and delete move each shifted entry with a read then
//   a write on the single memory, and find reads and compares one entry at a time
// reset: synchronous active low, clears length and control; entries are not cleared
`default_nettype none

module ordered_list_store_top #(
    parameter int CAPACITY  = ols_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ols_pkg::WORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ols_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ols_pkg::t_rsp      o_out_data
);

    localparam int ADDR_W = $clog2(CAPACITY);

    ols_pkg::t_done       done;
    logic                 slot_free;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic                 r_out_valid;
    ols_pkg::t_rsp        r_out_data;

    // sequencer
    ols_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_slot_free (slot_free),
        .o_done      (done),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    // entry memory
    ols_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register frees when empty or when its transfer completes
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && done.valid) begin
            r_out_data <= done.rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/ols_check.sv =====
// port checker for the ordered list store, bound to the top level
`default_nettype none

`include "ordered_list_store_top_macros.svh"

module ols_check #(
    parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire ols_pkg::t_req i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire ols_pkg::t_rsp o_out_data
);

    logic in_xfer;
    logic out_stall;
    logic out_fail;
    logic len_ok;
    logic pos_clear;
    logic rsp_legal;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_fail  = o_out_valid && (o_out_data.status != ols_pkg::STAT_OK);
    assign len_ok    = (CAPACITY >= 512) || (int'(o_out_data.length) <= CAPACITY);
    assign pos_clear = (o_out_data.found_position == '0);
    assign rsp_legal = len_ok && (o_out_data.status <= ols_pkg::STAT_NOTFOUND);

    // a stalled result holds
    `OLS_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data), "stall broken")

    // one request in work at a time
    `OLS_ASSERT_NEXT(a_one_at_a_time, in_xfer, !o_in_ready, "second request taken while busy")

    // a failed request reports no position
    `OLS_ASSERT_NOW(a_pos_zero, out_fail, pos_clear, "position on failed request")

    // length and status stay within their codes
    `OLS_ASSERT_NOW(a_len_status, o_out_valid, rsp_legal, "length or status out of range")

endmodule

bind ordered_list_store_top ols_check #(.CAPACITY(CAPACITY)) u_ols_check (.*);

`default_nettype wire

// ===== bench/tb_ordered_list_store_top.sv =====
// testbench for the ordered list store: directed and random requests checked against a list model
`timescale 1ns / 100ps
`default_nettype none

module tb_ordered_list_store_top;

    localparam int  CLK_HALF   = 5;
    localparam int  RESET_CYC  = 11;
    localparam int  RANDOM_N   = 1170;
    localparam int  CYCLE_CAP  = 4_000_000;
    localparam int  POOL_N     = 16;
    localparam int  REPORT_MAX = 10;
    localparam logic [ols_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic           req_valid = 1'b0;
    ols_pkg::t_req  req_data  = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    logic           rsp_ready = 1'b0;
    ols_pkg::t_rsp  o_out_data;

    // stimulus and expected results
    ols_pkg::t_req  pending_q[$];
    ols_pkg::t_rsp  expected_q[$];

    // list model state
    logic [ols_pkg::VALUE_W-1:0] list_words[ols_pkg::CAPACITY_DEF];
    int                          list_len = 0;

    // generation-time tracking of the list length
    int                          plan_len = 0;
    int                          random_count = 0;
    logic [ols_pkg::VALUE_W-1:0] word_pool[POOL_N];

    int  mismatch_count = 0;
    int  cycle_count = 0;

    // idling control
    int  send_gap = 0;
    bit  send_calm = 1'b0;
    int  take_gap = 0;
    bit  take_calm = 1'b0;

    ordered_list_store_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (req_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // list model: apply one request, return its result
    function automatic ols_pkg::t_rsp apply_list_request(input ols_pkg::t_req req);
        ols_pkg::t_rsp rsp;
        int            pos;
        int            i;
        rsp = '0;
        pos = int'(req.position);
        rsp.status = ols_pkg::STAT_OK;
        case (req.action)
            ols_pkg::ACT_INSERT: begin
                if (list_len >= ols_pkg::CAPACITY_DEF) begin
                    rsp.status = ols_pkg::STAT_FULL;
                end else if (pos > list_len) begin
                    rsp.status = ols_pkg::STAT_BADPOS;
                end else begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = req.value;
                    list_len++;
                end
            end
            ols_pkg::ACT_DELETE: begin
                if (list_len == 0) begin
                    rsp.status = ols_pkg::STAT_EMPTY;
                end else if (pos >= list_len) begin
                    rsp.status = ols_pkg::STAT_BADPOS;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            ols_pkg::ACT_FIND: begin
                rsp.status = ols_pkg::STAT_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (rsp.status == ols_pkg::STAT_NOTFOUND && list_words[i] == req.value) begin
                        rsp.status = ols_pkg::STAT_OK;
                        rsp.found_position = i[ols_pkg::FPOS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        rsp.length = list_len[ols_pkg::LEN_W-1:0];
        return rsp;
    endfunction

    // queue one request and follow its effect on the length
    task automatic queue_request(input logic [ols_pkg::ACT_W-1:0] act, input int pos,
                                 input logic [ols_pkg::VALUE_W-1:0] val);
        ols_pkg::t_req r;
        r.action   = act;
        r.position = pos[ols_pkg::POS_W-1:0];
        r.value    = val;
        pending_q.push_back(r);
        if (act == ols_pkg::ACT_INSERT && plan_len < ols_pkg::CAPACITY_DEF && pos <= plan_len)
            plan_len++;
        else if (act == ols_pkg::ACT_DELETE && plan_len > 0 && pos < plan_len)
            plan_len--;
    endtask

    // random request, mostly at legal positions and with values from a small pool
    task automatic queue_random(input int ins_pct, input int del_pct);
        int                          pick;
        int                          pos;
        logic [ols_pkg::ACT_W-1:0]   act;
        logic [ols_pkg::VALUE_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) act = ols_pkg::ACT_INSERT;
        else if (pick < ins_pct + del_pct) act = ols_pkg::ACT_DELETE;
        else if (pick < 96) act = ols_pkg::ACT_FIND;
        else act = ACT_UNUSED;
        val = ($urandom_range(0, 9) < 6) ? word_pool[$urandom_range(0, POOL_N-1)] : $urandom;
        if ($urandom_range(0, 99) < 85) begin
            if (act == ols_pkg::ACT_DELETE && plan_len > 0) pos = $urandom_range(0, plan_len - 1);
            else pos = $urandom_range(0, plan_len);
        end else begin
            pos = $urandom_range(0, 511);
        end
        queue_request(act, pos, val);
        random_count++;
    endtask

    // stimulus plan, then wait for the last result
    initial begin
        int k;
        for (k = 0; k < POOL_N; k++) word_pool[k] = $urandom;
        word_pool[0] = 32'h0000_0000;
        word_pool[1] = 32'hFFFF_FFFF;

        // empty list corners
        queue_request(ols_pkg::ACT_FIND,   0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 511, 32'hFFFF_FFFF);
        queue_request(ols_pkg::ACT_INSERT, 1,   32'h0000_0001);
        queue_request(ACT_UNUSED,          0,   32'h0000_0000);
        // into empty, append, front, middle with a duplicate
        queue_request(ols_pkg::ACT_INSERT, 0,   32'hFFFF_FFFF);
        queue_request(ols_pkg::ACT_INSERT, 1,   32'h0000_0000);
        queue_request(ols_pkg::ACT_INSERT, 0,   32'h1234_5678);
        queue_request(ols_pkg::ACT_INSERT, 1,   32'h0000_0000);
        queue_request(ols_pkg::ACT_FIND,   0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_FIND,   511, 32'hFFFF_FFFF);
        queue_request(ols_pkg::ACT_FIND,   0,   32'hDEAD_BEEF);
        // positions past the end
        queue_request(ols_pkg::ACT_INSERT, 5,   32'hAAAA_5555);
        queue_request(ols_pkg::ACT_INSERT, 511, 32'h5555_AAAA);
        queue_request(ols_pkg::ACT_INSERT, 256, 32'h0000_0002);
        queue_request(ols_pkg::ACT_DELETE, 4,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 511, 32'h0000_0000);
        queue_request(ACT_UNUSED,          511, 32'hFFFF_FFFF);
        // delete last, first, then down to empty
        queue_request(ols_pkg::ACT_DELETE, 3,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_FIND,   0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 0,   32'h0000_0000);
        queue_request(ols_pkg::ACT_FIND,   0,   32'h1234_5678);

        // mixed traffic on a short list
        for (k = 0; k < 300; k++) queue_random(45, 30);
        // fill to capacity, then hit the full list
        while (plan_len < ols_pkg::CAPACITY_DEF) queue_random(88, 4);
        queue_request(ols_pkg::ACT_INSERT, 0,   32'h0BAD_F00D);
        queue_request(ols_pkg::ACT_INSERT, 256, 32'h0BAD_F00D);
        queue_request(ols_pkg::ACT_FIND,   0,   32'h0BAD_F00D);
        queue_request(ols_pkg::ACT_DELETE, 256, 32'h0000_0000);
        queue_request(ols_pkg::ACT_DELETE, 255, 32'h0000_0000);
        queue_request(ols_pkg::ACT_INSERT, 255, 32'hFFFF_FFFF);
        queue_request(ols_pkg::ACT_INSERT, 100, 32'h0000_0000);
        for (k = 0; k < 20; k++) queue_random(50, 10);
        // drain to empty
        while (plan_len > 0) queue_random(5, 85);
        queue_request(ols_pkg::ACT_DELETE, 0, 32'h0000_0000);
        queue_request(ols_pkg::ACT_FIND,   0, word_pool[0]);
        // rest of the random traffic
        while (random_count < RANDOM_N) queue_random(40, 35);

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("PASS ordered_list_store_top");
        end else begin
            $display("FAIL ordered_list_store_top");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end else begin
            // transfer taken: predict its result and draw the next gap
            if (req_valid && o_in_ready) begin
                expected_q.push_back(apply_list_request(req_data));
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 12);
            end
            if (!req_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    req_data  <= pending_q.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        ols_pkg::t_rsp want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (o_out_valid && rsp_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result transfer: status %0d pos %0d len %0d",
                                 o_out_data.status, o_out_data.found_position,
                                 o_out_data.length);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_data.status !== want.status
                            || o_out_data.found_position !== want.found_position
                            || o_out_data.length !== want.length) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("expected status/pos/len %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.status, want.found_position, want.length,
                                     o_out_data.status, o_out_data.found_position,
                                     o_out_data.length);
                    end
                end
                if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
                take_gap = take_calm ? 0 : $urandom_range(0, 12);
            end
            if (take_gap > 0) begin
                take_gap--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL ordered_list_store_top");
            $finish;
        end
    end

endmodule

`default_nettype wire
